[rtl/sbtg_pkg.sv]
// Shared types and constants of the stereo beat tone generator.
package sbtg_pkg;

    // Sequencer states of the frame engine.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FADE,
        ST_FADE_DIV,
        ST_FADE_WAIT,
        ST_GAIN,
        ST_GAIN_R,
        ST_CAR,
        ST_CMUL,
        ST_CMUL_R,
        ST_SIN_Z,
        ST_SIN_A,
        ST_SIN_B,
        ST_SIN_C,
        ST_SIN_D,
        ST_PAN,
        ST_PAN_WAIT,
        ST_MIX0,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_MIX4,
        ST_DONE
    } state_t;

    // Frame commands.
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_STOP   = 3'd2;
    localparam logic [2:0] KIND_PAUSE  = 3'd3;
    localparam logic [2:0] KIND_RESUME = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_WAVE_LEFT      = 3'd0;
    localparam logic [2:0] REG_WAVE_RIGHT     = 3'd1;
    localparam logic [2:0] REG_STEP_LEFT      = 3'd2;
    localparam logic [2:0] REG_STEP_RIGHT     = 3'd3;
    localparam logic [2:0] REG_LEVEL          = 3'd4;
    localparam logic [2:0] REG_PAN_MODE       = 3'd5;
    localparam logic [2:0] REG_PAN_PERIOD     = 3'd6;
    localparam logic [2:0] REG_PAN_TRANSITION = 3'd7;

    // Waveform codes.
    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_TRI    = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;
    localparam logic [1:0] WAVE_SAW    = 2'd3;

    // Pan modes.
    localparam logic [1:0] PAN_SUM  = 2'd0;
    localparam logic [1:0] PAN_HOLD = 2'd1;
    localparam logic [1:0] PAN_SINE = 2'd2;
    localparam logic [1:0] PAN_EXT  = 2'd3;

    // Fade lengths in frames and unity gain in Q1.15.
    localparam logic [23:0] FADE_LONG_FRAMES  = 24'd72000;
    localparam logic [23:0] FADE_SHORT_FRAMES = 24'd24000;
    localparam logic [16:0] UNITY             = 17'd32768;

    // Sine phase quantization: 2**SINE_DEPTH_LOG2 steps per wave period.
    localparam int          SINE_DEPTH_LOG2 = 10;
    localparam logic [31:0] SINE_PH_MASK    = ~((32'd1 << (32 - SINE_DEPTH_LOG2)) - 32'd1);

    // Output resolution; low bits below it are cleared.
    localparam int          SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MASK = 16'hFFFF << (16 - SAMPLE_BITS);

    // Shared divider geometry.
    localparam int DIV_DVD_W = 56;
    localparam int DIV_DVS_W = 24;
    localparam int DIV_CNT_W = 6;

endpackage

[rtl/sbtg_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module sbtg_div import sbtg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_DVD_W-1:0] dividend,
    input  logic [DIV_DVS_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_DVD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DVS_W:0]   rem_reg;
    logic [DIV_DVD_W-1:0] quo_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;

    logic [DIV_DVS_W:0]   rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg[DIV_DVS_W-1:0], quo_reg[DIV_DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_DVD_W-2:0], fits};
            rem_reg <= fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/stereo_beat_tone_generator.sv]
// Top level of the stereo beat tone generator: sequencer, shared multiplier and state.
//
// Usage. Each transfer on the s_ channel is one audio frame: s_tuser carries the
// command (none, start, stop, pause, resume) and s_tdata the external pan position.
// Each accepted frame gives exactly one transfer on the m_ channel with the left
// and right samples in m_tdata and the fading and paused flags in m_tuser.
// Registers are written over the cfg_ channel, which is always ready; they are
// meant to be changed only while no frame is in flight.
// Timing. Before the first start a frame goes from idle straight to the output
// stage. Otherwise the frame time is set by the single 33x18 multiplier, which
// serves the fade gain, both carriers, the sine polynomial and the pan mix in turn,
// and by the one-bit-per-cycle divider (56 steps), used once for a fade ramp and
// once more for the hold-and-crossfade or sinusoidal pan modes.
// The block takes one frame at a time; s_tready is high only while the sequencer
// is idle. A finished result sits in the output register, so a new frame can be
// taken while the receiver stalls; that frame then waits at its end until the
// output register is free. After reset the generator state is clear, the registers hold
// their defaults, and frames give zero samples until a start command arrives.
module stereo_beat_tone_generator import sbtg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] follow_value
    input  logic [2:0]  s_tuser,    // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] left_sample, [31:16] right_sample
    output logic [1:0]  m_tuser,    // [0] is_fading, [1] is_paused
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic [1:0]  wave_l_reg, wave_r_reg;
    logic [31:0] step_l_reg, step_r_reg;
    logic [15:0] level_reg;
    logic [1:0]  pan_mode_reg;
    logic [23:0] pan_period_reg, pan_trans_reg;

    // Persistent generator state.
    state_t      state_reg, state_next;
    logic [31:0] phase_l_reg, phase_l_next, phase_r_reg, phase_r_next;
    logic        running_reg, running_next, paused_reg, paused_next;
    logic        fading_reg, fading_next, fhigh_reg, fhigh_next, fshort_reg, fshort_next;
    logic [15:0] gain_reg, gain_next, fstart_reg, fstart_next;
    logic [23:0] felapsed_reg, felapsed_next;
    logic [24:0] pan_cyc_reg, pan_cyc_next;
    logic [23:0] pan_wav_reg, pan_wav_next;

    // Per-frame working registers.
    logic [15:0]        follow_reg, follow_next;
    logic signed [50:0] prod_reg, acc_reg, acc_next;
    logic [30:0]        g_reg, g_next;
    logic               side_reg, side_next;
    logic signed [17:0] car_reg, car_next, ml_reg, ml_next, mr_reg, mr_next;
    logic signed [17:0] pl_reg, pl_next, pr_reg, pr_next;
    logic [31:0]        sin_ph_reg, sin_ph_next;
    logic               sin_pan_reg, sin_pan_next, pan_inv_reg, pan_inv_next;
    logic [16:0]        z_reg, z_next, z2_reg, z2_next;
    logic [1:0]         quad_reg, quad_next;
    logic [15:0]        left_reg, left_next, right_reg, right_next;

    // Output register.
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    // Shared multiplier and divider hookup.
    logic signed [32:0]    mul_a;
    logic signed [17:0]    mul_b;
    logic signed [50:0]    mul_p;
    logic                  div_start, div_done;
    logic [DIV_DVD_W-1:0]  div_dvd, div_q;
    logic [DIV_DVS_W-1:0]  div_dvs;

    // Combinational helpers.
    logic               run_after;
    logic [23:0]        flen;
    logic [24:0]        el1;
    logic [16:0]        absdiff;
    logic [23:0]        per, tr0, tr;
    logic [24:0]        full, hold_end, full_end, c, cyc_inc, pan_diff;
    logic [23:0]        wc, wav_inc;
    logic [31:0]        cur_ph, d_abs, q_ph;
    logic [1:0]         cur_wave;
    logic signed [17:0] car_tri, car_saw, car_sq;
    logic [30:0]        u;
    logic [16:0]        z, t1, t;
    logic [19:0]        s_inc;
    logic [16:0]        s_cl;
    logic signed [17:0] sin_val, sin_x, m_val;
    logic signed [50:0] prod_sh;
    logic signed [51:0] mix_sum, mix_sh;
    logic [15:0]        mix_sat, fin;
    logic [16:0]        qx, xv;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    sbtg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mul_p = mul_a * mul_b;

    // Fade arithmetic.
    assign run_after = running_reg || (s_tuser == KIND_START);
    assign flen      = fshort_reg ? FADE_SHORT_FRAMES : FADE_LONG_FRAMES;
    assign el1       = {1'b0, felapsed_reg} + 25'd1;
    assign absdiff   = fhigh_reg ? (UNITY - {1'b0, fstart_reg}) : {1'b0, fstart_reg};

    // Pan geometry with the degenerate period and transition values cleaned up.
    assign per      = (pan_period_reg == 24'd0) ? 24'd1 : pan_period_reg;
    assign tr0      = (pan_trans_reg == 24'd0) ? 24'd1 : pan_trans_reg;
    assign tr       = (tr0 > per) ? per : tr0;
    assign full     = {per, 1'b0};
    assign hold_end = {1'b0, per} - {1'b0, tr};
    assign full_end = full - {1'b0, tr};
    assign c        = (pan_cyc_reg >= full) ? 25'd0 : pan_cyc_reg;
    assign cyc_inc  = pan_cyc_reg + 25'd1;
    assign pan_diff = (c < {1'b0, per}) ? (c - hold_end) : (c - full_end);
    assign wc       = (pan_wav_reg >= per) ? 24'd0 : pan_wav_reg;
    assign wav_inc  = pan_wav_reg + 24'd1;

    // Non-sine carriers straight from the phase.
    assign cur_ph   = side_reg ? phase_r_reg : phase_l_reg;
    assign cur_wave = side_reg ? wave_r_reg : wave_l_reg;
    assign d_abs    = cur_ph[31] ? (32'd0 - cur_ph) : cur_ph;
    assign car_tri  = $signed({1'b0, d_abs[31:15]}) - 18'sd32768;
    assign car_saw  = $signed({{2{cur_ph[31]}}, cur_ph[31:16]});
    assign car_sq   = cur_ph[31] ? -18'sd32768 : 18'sd32768;

    // Sine polynomial operands, one quarter wave folded onto the first.
    assign q_ph    = sin_ph_reg & SINE_PH_MASK;
    assign u       = q_ph[30] ? (31'h4000_0000 - {1'b0, q_ph[29:0]}) : {1'b0, q_ph[29:0]};
    assign z       = u[30:14];
    assign t1      = 17'd42334 - prod_reg[32:16];
    assign t       = 17'd102944 - 17'(prod_reg[33:16]);
    assign s_inc   = prod_reg[35:16] + 20'd1;
    assign s_cl    = (s_inc[19:1] > 19'd32768) ? UNITY : s_inc[17:1];
    assign sin_val = quad_reg[1] ? -$signed({1'b0, s_cl}) : $signed({1'b0, s_cl});
    assign sin_x   = sin_val + 18'sd32768;

    // Carrier scaling result, floored by the arithmetic shift.
    assign prod_sh = prod_reg >>> 30;
    assign m_val   = prod_sh[17:0];

    // Mix sum, floored, saturated and reduced to the sample resolution.
    assign mix_sum = acc_reg + prod_reg;
    assign mix_sh  = mix_sum >>> 16;
    always_comb begin
        if (mix_sh > 52'sd32767) begin
            mix_sat = 16'h7FFF;
        end else if (mix_sh < -52'sd32768) begin
            mix_sat = 16'h8000;
        end else begin
            mix_sat = mix_sh[15:0];
        end
    end
    assign fin = mix_sat & SAMPLE_MASK;

    // Crossfade position from the divider, mirrored on the way back.
    assign qx = {1'b0, div_q[15:0]};
    assign xv = pan_inv_reg ? (17'd65536 - qx) : qx;

    always_comb begin
        state_next    = state_reg;
        phase_l_next  = phase_l_reg;
        phase_r_next  = phase_r_reg;
        running_next  = running_reg;
        paused_next   = paused_reg;
        fading_next   = fading_reg;
        fhigh_next    = fhigh_reg;
        fshort_next   = fshort_reg;
        gain_next     = gain_reg;
        fstart_next   = fstart_reg;
        felapsed_next = felapsed_reg;
        pan_cyc_next  = pan_cyc_reg;
        pan_wav_next  = pan_wav_reg;
        follow_next   = follow_reg;
        acc_next      = acc_reg;
        g_next        = g_reg;
        side_next     = side_reg;
        car_next      = car_reg;
        ml_next       = ml_reg;
        mr_next       = mr_reg;
        pl_next       = pl_reg;
        pr_next       = pr_reg;
        sin_ph_next   = sin_ph_reg;
        sin_pan_next  = sin_pan_reg;
        pan_inv_next  = pan_inv_reg;
        z_next        = z_reg;
        z2_next       = z2_reg;
        quad_next     = quad_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_dvd       = '0;
        div_dvs       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    follow_next = s_tdata;
                    left_next   = '0;
                    right_next  = '0;
                    case (s_tuser)
                        KIND_START: begin
                            running_next  = 1'b1;
                            paused_next   = 1'b0;
                            gain_next     = '0;
                            fstart_next   = '0;
                            fhigh_next    = 1'b1;
                            fshort_next   = 1'b0;
                            felapsed_next = '0;
                            fading_next   = 1'b1;
                        end
                        KIND_STOP: begin
                            fstart_next   = gain_reg;
                            fhigh_next    = 1'b0;
                            fshort_next   = 1'b0;
                            felapsed_next = '0;
                            fading_next   = 1'b1;
                        end
                        KIND_PAUSE: begin
                            fstart_next   = fading_reg ? gain_reg : UNITY[15:0];
                            fhigh_next    = 1'b0;
                            fshort_next   = 1'b1;
                            felapsed_next = '0;
                            fading_next   = 1'b1;
                        end
                        KIND_RESUME: begin
                            paused_next   = 1'b0;
                            fstart_next   = gain_reg;
                            fhigh_next    = 1'b1;
                            fshort_next   = 1'b1;
                            felapsed_next = '0;
                            fading_next   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    state_next = run_after ? ST_FADE : ST_DONE;
                end
            end
            ST_FADE: begin
                if (fading_reg) begin
                    felapsed_next = el1[23:0];
                    if (el1 >= {1'b0, flen}) begin
                        gain_next   = fhigh_reg ? UNITY[15:0] : 16'd0;
                        fading_next = 1'b0;
                        if (!fhigh_reg) begin
                            paused_next = 1'b1;
                        end
                        state_next = ST_GAIN;
                    end else begin
                        mul_a      = {8'd0, el1};
                        mul_b      = {1'b0, absdiff};
                        state_next = ST_FADE_DIV;
                    end
                end else begin
                    state_next = ST_GAIN;
                end
            end
            ST_FADE_DIV: begin
                div_start  = 1'b1;
                div_dvd    = {5'd0, prod_reg};
                div_dvs    = flen;
                state_next = ST_FADE_WAIT;
            end
            ST_FADE_WAIT: begin
                if (div_done) begin
                    gain_next  = fhigh_reg ? (fstart_reg + div_q[15:0])
                                           : (fstart_reg - div_q[15:0]);
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                mul_a      = {17'd0, level_reg};
                mul_b      = {2'd0, gain_reg};
                state_next = ST_GAIN_R;
            end
            ST_GAIN_R: begin
                g_next     = prod_reg[30:0];
                side_next  = 1'b0;
                state_next = ST_CAR;
            end
            ST_CAR: begin
                unique case (cur_wave)
                    WAVE_SINE: begin
                        sin_ph_next  = cur_ph;
                        sin_pan_next = 1'b0;
                        state_next   = ST_SIN_Z;
                    end
                    WAVE_TRI: begin
                        car_next   = car_tri;
                        state_next = ST_CMUL;
                    end
                    WAVE_SQUARE: begin
                        car_next   = car_sq;
                        state_next = ST_CMUL;
                    end
                    WAVE_SAW: begin
                        car_next   = car_saw;
                        state_next = ST_CMUL;
                    end
                endcase
            end
            ST_CMUL: begin
                mul_a      = {2'd0, g_reg};
                mul_b      = car_reg;
                state_next = ST_CMUL_R;
            end
            ST_CMUL_R: begin
                if (side_reg) begin
                    mr_next    = m_val;
                    state_next = ST_PAN;
                end else begin
                    ml_next    = m_val;
                    side_next  = 1'b1;
                    state_next = ST_CAR;
                end
            end
            ST_SIN_Z: begin
                z_next     = z;
                quad_next  = q_ph[31:30];
                mul_a      = {16'd0, z};
                mul_b      = {1'b0, z};
                state_next = ST_SIN_A;
            end
            ST_SIN_A: begin
                z2_next    = prod_reg[32:16];
                mul_a      = 33'sd4926;
                mul_b      = {1'b0, prod_reg[32:16]};
                state_next = ST_SIN_B;
            end
            ST_SIN_B: begin
                mul_a      = {16'd0, t1};
                mul_b      = {1'b0, z2_reg};
                state_next = ST_SIN_C;
            end
            ST_SIN_C: begin
                mul_a      = {16'd0, t};
                mul_b      = {1'b0, z_reg};
                state_next = ST_SIN_D;
            end
            ST_SIN_D: begin
                if (sin_pan_reg) begin
                    pl_next    = 18'sd65536 - sin_x;
                    pr_next    = sin_x;
                    state_next = ST_MIX0;
                end else begin
                    car_next   = sin_val;
                    state_next = ST_CMUL;
                end
            end
            ST_PAN: begin
                unique case (pan_mode_reg)
                    PAN_SUM: begin
                        pl_next    = 18'sd65536;
                        pr_next    = 18'sd65536;
                        state_next = ST_MIX0;
                    end
                    PAN_HOLD: begin
                        pan_cyc_next = c;
                        if (c < hold_end) begin
                            pl_next    = 18'sd65536;
                            pr_next    = 18'sd0;
                            state_next = ST_MIX0;
                        end else if ((c >= {1'b0, per}) && (c < full_end)) begin
                            pl_next    = 18'sd0;
                            pr_next    = 18'sd65536;
                            state_next = ST_MIX0;
                        end else begin
                            div_start    = 1'b1;
                            div_dvd      = {15'd0, pan_diff, 16'd0};
                            div_dvs      = tr;
                            pan_inv_next = (c >= {1'b0, per});
                            state_next   = ST_PAN_WAIT;
                        end
                    end
                    PAN_SINE: begin
                        pan_wav_next = wc;
                        div_start    = 1'b1;
                        div_dvd      = {wc, 32'd0};
                        div_dvs      = per;
                        state_next   = ST_PAN_WAIT;
                    end
                    PAN_EXT: begin
                        pl_next    = 18'sd65536 - $signed({2'd0, follow_reg});
                        pr_next    = $signed({2'd0, follow_reg});
                        state_next = ST_MIX0;
                    end
                endcase
            end
            ST_PAN_WAIT: begin
                if (div_done) begin
                    if (pan_mode_reg == PAN_SINE) begin
                        sin_ph_next  = div_q[31:0];
                        sin_pan_next = 1'b1;
                        state_next   = ST_SIN_Z;
                    end else begin
                        pl_next    = 18'sd65536 - $signed({1'b0, xv});
                        pr_next    = $signed({1'b0, xv});
                        state_next = ST_MIX0;
                    end
                end
            end
            ST_MIX0: begin
                mul_a      = {{15{pl_reg[17]}}, pl_reg};
                mul_b      = ml_reg;
                state_next = ST_MIX1;
            end
            ST_MIX1: begin
                acc_next   = prod_reg;
                mul_a      = {{15{pr_reg[17]}}, pr_reg};
                mul_b      = mr_reg;
                state_next = ST_MIX2;
            end
            ST_MIX2: begin
                left_next  = fin;
                mul_a      = {{15{pl_reg[17]}}, pl_reg};
                mul_b      = mr_reg;
                state_next = ST_MIX3;
            end
            ST_MIX3: begin
                acc_next   = prod_reg;
                mul_a      = {{15{pr_reg[17]}}, pr_reg};
                mul_b      = ml_reg;
                state_next = ST_MIX4;
            end
            ST_MIX4: begin
                right_next = fin;
                // Phases and pan counters move on only while not frozen.
                if (!paused_reg) begin
                    phase_l_next = phase_l_reg + step_l_reg;
                    phase_r_next = phase_r_reg + step_r_reg;
                    if (pan_mode_reg == PAN_HOLD) begin
                        pan_cyc_next = (cyc_inc >= full) ? 25'd0 : cyc_inc;
                    end else if (pan_mode_reg == PAN_SINE) begin
                        pan_wav_next = (wav_inc >= per) ? 24'd0 : wav_inc;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {right_reg, left_reg};
                    m_tuser_next  = {paused_reg, fading_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_l_reg     <= WAVE_SINE;
            wave_r_reg     <= WAVE_SINE;
            step_l_reg     <= '0;
            step_r_reg     <= '0;
            level_reg      <= UNITY[15:0];
            pan_mode_reg   <= PAN_SUM;
            pan_period_reg <= 24'd48000;
            pan_trans_reg  <= 24'd4800;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WAVE_LEFT:      wave_l_reg     <= cfg_data[1:0];
                REG_WAVE_RIGHT:     wave_r_reg     <= cfg_data[1:0];
                REG_STEP_LEFT:      step_l_reg     <= cfg_data;
                REG_STEP_RIGHT:     step_r_reg     <= cfg_data;
                REG_LEVEL:          level_reg      <= cfg_data[15:0];
                REG_PAN_MODE:       pan_mode_reg   <= cfg_data[1:0];
                REG_PAN_PERIOD:     pan_period_reg <= cfg_data[23:0];
                REG_PAN_TRANSITION: pan_trans_reg  <= cfg_data[23:0];
            endcase
        end
    end

    // Control and persistent state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_l_reg  <= '0;
            phase_r_reg  <= '0;
            running_reg  <= 1'b0;
            paused_reg   <= 1'b0;
            fading_reg   <= 1'b0;
            fhigh_reg    <= 1'b0;
            fshort_reg   <= 1'b0;
            gain_reg     <= '0;
            fstart_reg   <= '0;
            felapsed_reg <= '0;
            pan_cyc_reg  <= '0;
            pan_wav_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_l_reg  <= phase_l_next;
            phase_r_reg  <= phase_r_next;
            running_reg  <= running_next;
            paused_reg   <= paused_next;
            fading_reg   <= fading_next;
            fhigh_reg    <= fhigh_next;
            fshort_reg   <= fshort_next;
            gain_reg     <= gain_next;
            fstart_reg   <= fstart_next;
            felapsed_reg <= felapsed_next;
            pan_cyc_reg  <= pan_cyc_next;
            pan_wav_reg  <= pan_wav_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg    <= mul_p;
        acc_reg     <= acc_next;
        follow_reg  <= follow_next;
        g_reg       <= g_next;
        side_reg    <= side_next;
        car_reg     <= car_next;
        ml_reg      <= ml_next;
        mr_reg      <= mr_next;
        pl_reg      <= pl_next;
        pr_reg      <= pr_next;
        sin_ph_reg  <= sin_ph_next;
        sin_pan_reg <= sin_pan_next;
        pan_inv_reg <= pan_inv_next;
        z_reg       <= z_next;
        z2_reg      <= z2_next;
        quad_reg    <= quad_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef SYNTHESIS
    // The fade gain never rises above unity.
    a_gain_max: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= UNITY[15:0])
        else $error("fade gain above unity");

    // Before the first start a frame completes with silent samples.
    a_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !running_reg) |-> (left_reg == 16'd0 && right_reg == 16'd0))
        else $error("samples not silent while not running");

    // The divider only reports back to a state that waits for it.
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_FADE_WAIT || state_reg == ST_PAN_WAIT))
        else $error("divider finished with nobody waiting");

    // Between frames a running ramp has not yet reached its length.
    a_ramp_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && fading_reg) |-> (felapsed_reg < flen))
        else $error("fade ramp overran its length");

    // An accepted frame always leaves the idle state.
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("frame accepted but sequencer stayed idle");
`endif

endmodule
